>>> hw/rtl/fbfla_pkg.sv
// fbfla_pkg: shared widths, register indexes and status codes for the
// fixed-size block free-list allocator; no dependencies
`default_nettype none

package fbfla_pkg;

  localparam int MAX_BLOCKS   = 256;
  localparam int HEADER_BYTES = 8;

  localparam int IDX_W    = $clog2(MAX_BLOCKS);   // block index width
  localparam int CNT_W    = IDX_W + 1;            // holds MAX_BLOCKS itself
  localparam int PAY_W    = 13;                   // payload_bytes register
  localparam int STRIDE_W = PAY_W + 1;            // header plus payload
  localparam int OFF_W    = 20;                   // block_offset field
  localparam int PROD_W   = IDX_W + STRIDE_W;     // full index * stride
  localparam int STAT_W   = 2;
  localparam int CFG_W    = PAY_W;                // widest register
  localparam int CFG_IDX_W = 1;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [STAT_W-1:0] status_t;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_BYTES = 1'b1;

  // request codes
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // result status codes
  localparam status_t ST_GRANTED = 2'd0;
  localparam status_t ST_EMPTY   = 2'd1;
  localparam status_t ST_FREED   = 2'd2;

  // register reset values
  localparam cnt_t                BLOCKS_RESET  = cnt_t'(MAX_BLOCKS);
  localparam logic [PAY_W-1:0]    PAYLOAD_RESET = PAY_W'(64);

endpackage

`default_nettype wire

>>> hw/rtl/fixed_block_free_list_allocator.sv
// fixed_block_free_list_allocator: lifo free list over a pool of equal blocks,
// link store in one synchronous memory; depends on fbfla_pkg
//
// timing: a free gives its result in the cycle after acceptance and busy stays
//   low, so frees can follow each other every cycle while no register write is
//   made; an allocate holds busy high in S_ALLOC while the link memory read
//   returns and gives its result as it leaves, so allocates do not overlap
// reset: synchronous rst clears control state, registers take their defaults
//   (256 blocks, 64 payload bytes) and the list restarts at block 0; the link
//   memory is not cleared, the fresh counter covers never-linked blocks
// results are shown for one cycle on done; the receiver cannot stall
`default_nettype none

module fixed_block_free_list_allocator (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // command side
  input  wire logic                               start,
  output      logic                               busy,
  input  wire logic                               req_type,
  input  wire logic [fbfla_pkg::IDX_W-1:0]        free_index,
  // result side
  output      logic                               done,
  output      logic [fbfla_pkg::STAT_W-1:0]       status,
  output      logic [fbfla_pkg::IDX_W-1:0]        block_index,
  output      logic [fbfla_pkg::OFF_W-1:0]        block_offset,
  // configuration
  input  wire logic                               cfg_wr_en,
  input  wire logic [fbfla_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [fbfla_pkg::CFG_W-1:0]        cfg_data
);

  // sequencer codes
  localparam logic S_IDLE  = 1'b0;
  localparam logic S_ALLOC = 1'b1;   // link read in flight, decide and grant

  logic state;

  // configuration registers
  fbfla_pkg::cnt_t                blocks_in_use;
  logic [fbfla_pkg::PAY_W-1:0]    payload_bytes;

  // free-list control state
  fbfla_pkg::idx_t list_head;
  logic            list_empty;
  fbfla_pkg::cnt_t fresh_count;

  // link memory: successor of each pushed block, self link ends the list
  fbfla_pkg::idx_t next_link [fbfla_pkg::MAX_BLOCKS];
  fbfla_pkg::idx_t link_rd;

  logic accept;
  logic do_free;
  logic do_alloc;

  assign accept   = start && !busy;
  assign do_free  = accept && (req_type == fbfla_pkg::REQ_FREE);
  assign do_alloc = accept && (req_type == fbfla_pkg::REQ_ALLOC);
  assign busy     = (state == S_ALLOC);

  // pool size capped at the built depth
  fbfla_pkg::cnt_t pool_n;
  assign pool_n = (blocks_in_use > fbfla_pkg::cnt_t'(fbfla_pkg::MAX_BLOCKS))
                ? fbfla_pkg::cnt_t'(fbfla_pkg::MAX_BLOCKS) : blocks_in_use;

  // link memory: one write port for pushes, registered read of the head
  always_ff @(posedge clk) begin
    if (do_free) begin
      next_link[free_index] <= list_empty ? free_index : list_head;
    end
    link_rd <= next_link[list_head];
  end

  // allocate decision, evaluated while the link read returns
  fbfla_pkg::cnt_t head_ext;
  fbfla_pkg::cnt_t head_inc;
  logic            in_fresh;
  logic            fresh_out;
  logic            grant;

  assign head_ext  = {1'b0, list_head};
  assign head_inc  = head_ext + fbfla_pkg::cnt_t'(1);
  assign in_fresh  = (head_ext == fresh_count);
  assign fresh_out = in_fresh && (fresh_count >= pool_n);
  assign grant     = !list_empty && !fresh_out;

  // payload offset of the head block, header included, wraps to 20 bits
  logic [fbfla_pkg::STRIDE_W-1:0] stride;
  logic [fbfla_pkg::PROD_W-1:0]   offset_full;

  assign stride      = fbfla_pkg::STRIDE_W'(fbfla_pkg::HEADER_BYTES)
                     + {1'b0, payload_bytes};
  assign offset_full = fbfla_pkg::PROD_W'(list_head) * fbfla_pkg::PROD_W'(stride)
                     + fbfla_pkg::PROD_W'(fbfla_pkg::HEADER_BYTES);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      done          <= 1'b0;
      blocks_in_use <= fbfla_pkg::BLOCKS_RESET;
      payload_bytes <= fbfla_pkg::PAYLOAD_RESET;
      list_head     <= '0;
      list_empty    <= 1'b0;
      fresh_count   <= '0;
    end else begin
      done <= 1'b0;
      if (cfg_wr_en) begin
        // any register write restarts the pool, links are kept
        unique case (cfg_index)
          fbfla_pkg::REG_BLOCKS_IN_USE: blocks_in_use <= cfg_data[fbfla_pkg::CNT_W-1:0];
          fbfla_pkg::REG_PAYLOAD_BYTES: payload_bytes <= cfg_data;
          default: ;
        endcase
        list_head   <= '0;
        list_empty  <= 1'b0;
        fresh_count <= '0;
      end else begin
        unique case (state)
          S_IDLE: begin
            if (do_free) begin
              // push onto the head, result on the next cycle
              list_head  <= free_index;
              list_empty <= 1'b0;
              done       <= 1'b1;
            end else if (do_alloc) begin
              state <= S_ALLOC;
            end
          end
          S_ALLOC: begin
            state <= S_IDLE;
            done  <= 1'b1;
            if (!list_empty) begin
              if (in_fresh) begin
                if (fresh_out) begin
                  list_empty <= 1'b1;
                end else begin
                  // head still in the never-linked tail: step to the next one
                  fresh_count <= fresh_count + fbfla_pkg::cnt_t'(1);
                  if (head_inc >= pool_n) begin
                    list_empty <= 1'b1;
                  end else begin
                    list_head <= head_inc[fbfla_pkg::IDX_W-1:0];
                  end
                end
              end else if (link_rd == list_head) begin
                list_empty <= 1'b1;
              end else begin
                list_head <= link_rd;
              end
            end
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

  // result payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      status       <= fbfla_pkg::ST_FREED;
      block_index  <= '0;
      block_offset <= '0;
    end else if (grant) begin
      status       <= fbfla_pkg::ST_GRANTED;
      block_index  <= list_head;
      block_offset <= offset_full[fbfla_pkg::OFF_W-1:0];
    end else begin
      status       <= fbfla_pkg::ST_EMPTY;
      block_index  <= '0;
      block_offset <= '0;
    end
  end

endmodule

`default_nettype wire
